// ===== rtl/code_length_run_length_encoder_assert.svh =====
// assertion helpers for the code length run length encoder
`ifndef CODE_LENGTH_RUN_LENGTH_ENCODER_ASSERT_SVH
`define CODE_LENGTH_RUN_LENGTH_ENCODER_ASSERT_SVH

// checked only outside reset
`define CLRLE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CLRLE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/clrle_pkg.sv =====
`timescale 1ns / 1ps

package clrle_pkg;

    typedef struct packed {
        logic [3:0] code_length;
        logic       table_end;
    } t_in_item;

    typedef struct packed {
        logic [4:0] symbol;
        logic [6:0] extra_value;
        logic [2:0] extra_width;
        logic       last_of_run;
        logic       table_done;
    } t_out_item;

    typedef struct packed {
        logic [7:0] run_count;
        logic [4:0] previous_length;
        logic [7:0] run_max;
        logic [2:0] run_min;
    } t_run_state;

    localparam logic [3:0] MAX_CODE_LENGTH = 4'd15;
    localparam logic [4:0] NO_LENGTH       = 5'd16;

    localparam logic [4:0] SYM_REPEAT      = 5'd16;
    localparam logic [4:0] SYM_ZEROS_SHORT = 5'd17;
    localparam logic [4:0] SYM_ZEROS_LONG  = 5'd18;

    localparam logic [2:0] EW_REPEAT       = 3'd2;
    localparam logic [2:0] EW_ZEROS_SHORT  = 3'd3;
    localparam logic [2:0] EW_ZEROS_LONG   = 3'd7;

    localparam logic [7:0] RUN_MAX_ZERO    = 8'd138;
    localparam logic [7:0] RUN_MAX_REPEAT  = 8'd6;
    localparam logic [7:0] RUN_MAX_OTHER   = 8'd7;
    localparam logic [2:0] RUN_MIN_SHORT   = 3'd3;
    localparam logic [2:0] RUN_MIN_OTHER   = 3'd4;

    localparam logic [7:0] REPEAT_BASE     = 8'd3;
    localparam logic [7:0] SHORT_ZERO_MAX  = 8'd10;
    localparam logic [7:0] LONG_ZERO_BASE  = 8'd11;

    localparam t_run_state RUN_STATE_RESET = '{
        run_count:       8'd0,
        previous_length: NO_LENGTH,
        run_max:         RUN_MAX_OTHER,
        run_min:         RUN_MIN_OTHER
    };

    function automatic t_out_item make_result(
        input logic [4:0] symbol,
        input logic [6:0] extra_value,
        input logic [2:0] extra_width
    );
        t_out_item r;
        r.symbol      = symbol;
        r.extra_value = extra_value;
        r.extra_width = extra_width;
        r.last_of_run = 1'b0;
        r.table_done  = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/clrle_advance.sv =====
`timescale 1ns / 1ps

module clrle_advance (
    input  clrle_pkg::t_run_state            i_state,
    input  logic [3:0]                       i_cur,
    input  logic [3:0]                       i_next,
    input  logic                             i_guard,
    output clrle_pkg::t_run_state            o_state,
    output clrle_pkg::t_out_item [2:0]       o_res,
    output logic [1:0]                       o_count
);
    import clrle_pkg::*;

    logic [7:0] cnt;
    logic [7:0] cnt_rep;
    logic [7:0] sub_rep;
    logic [7:0] sub_short;
    logic [7:0] sub_long;
    logic [4:0] cur_ext;
    logic       extend;
    logic [1:0] idx;

    always_comb begin
        cnt       = i_state.run_count + 8'd1;
        cur_ext   = {1'b0, i_cur};
        extend    = !i_guard && (cnt < i_state.run_max) && (i_cur == i_next);
        cnt_rep   = cnt;
        idx       = 2'd0;
        sub_short = cnt - REPEAT_BASE;
        sub_long  = cnt - LONG_ZERO_BASE;
        o_state   = i_state;
        o_res     = '0;
        o_count   = 2'd0;

        if (cur_ext != i_state.previous_length) begin
            cnt_rep = cnt - 8'd1;
            idx     = 2'd1;
        end
        sub_rep = cnt_rep - REPEAT_BASE;

        if (extend) begin
            o_state.run_count = cnt;
        end else begin
            if (cnt < {5'd0, i_state.run_min}) begin
                // short run goes out as plain literals
                for (int k = 0; k < 3; k++) begin
                    o_res[k] = make_result(cur_ext, 7'd0, 3'd0);
                end
                o_count = cnt[1:0];
            end else if (i_cur != 4'd0) begin
                // literal first unless it repeats the last one sent
                o_res[0] = make_result(cur_ext, 7'd0, 3'd0);
                o_res[idx] = make_result(SYM_REPEAT,
                    (cnt_rep >= REPEAT_BASE) ? {5'd0, sub_rep[1:0]} : 7'd0, EW_REPEAT);
                o_count = idx + 2'd1;
            end else if (cnt <= SHORT_ZERO_MAX) begin
                o_res[0] = make_result(SYM_ZEROS_SHORT,
                    (cnt >= REPEAT_BASE) ? {4'd0, sub_short[2:0]} : 7'd0, EW_ZEROS_SHORT);
                o_count = 2'd1;
            end else begin
                o_res[0] = make_result(SYM_ZEROS_LONG, sub_long[6:0], EW_ZEROS_LONG);
                o_count = 2'd1;
            end

            o_state.run_count       = 8'd0;
            o_state.previous_length = cur_ext;
            if (i_guard) begin
                o_state.run_max = RUN_MAX_OTHER;
                o_state.run_min = RUN_MIN_OTHER;
            end else if (i_next == 4'd0) begin
                o_state.run_max = RUN_MAX_ZERO;
                o_state.run_min = RUN_MIN_SHORT;
            end else if (i_cur == i_next) begin
                o_state.run_max = RUN_MAX_REPEAT;
                o_state.run_min = RUN_MIN_SHORT;
            end else begin
                o_state.run_max = RUN_MAX_OTHER;
                o_state.run_min = RUN_MIN_OTHER;
            end
        end
    end

endmodule

// ===== rtl/clrle_step.sv =====
`timescale 1ns / 1ps

module clrle_step (
    input  logic                             i_have_pending,
    input  logic [3:0]                       i_pending_length,
    input  clrle_pkg::t_run_state            i_state,
    input  clrle_pkg::t_in_item              i_item,
    output logic                             o_have_pending,
    output logic [3:0]                       o_pending_length,
    output clrle_pkg::t_run_state            o_state,
    output clrle_pkg::t_out_item [5:0]       o_list,
    output logic [2:0]                       o_count
);
    import clrle_pkg::*;

    logic [3:0]       len;
    t_run_state       adv1_state;
    t_out_item [2:0]  adv1_res;
    logic [1:0]       adv1_count;
    t_run_state       mid_state;
    t_run_state       adv2_state;
    t_out_item [2:0]  adv2_res;
    logic [1:0]       adv2_count;
    logic [1:0]       n1;
    logic [1:0]       n2;
    logic [2:0]       kk;
    logic [2:0]       j;
    logic [2:0]       last_idx;

    assign len = (i_item.code_length > MAX_CODE_LENGTH) ? MAX_CODE_LENGTH : i_item.code_length;

    // held length against the new one
    clrle_advance u_adv_held (
        .i_state (i_state),
        .i_cur   (i_pending_length),
        .i_next  (len),
        .i_guard (1'b0),
        .o_state (adv1_state),
        .o_res   (adv1_res),
        .o_count (adv1_count)
    );

    // flush of the new length at table end
    clrle_advance u_adv_flush (
        .i_state (mid_state),
        .i_cur   (len),
        .i_next  (4'd0),
        .i_guard (1'b1),
        .o_state (adv2_state),
        .o_res   (adv2_res),
        .o_count (adv2_count)
    );

    always_comb begin
        if (i_have_pending) begin
            mid_state = adv1_state;
            n1        = adv1_count;
        end else begin
            mid_state                 = RUN_STATE_RESET;
            mid_state.previous_length = NO_LENGTH;
            mid_state.run_count       = 8'd0;
            if (len == 4'd0) begin
                mid_state.run_max = RUN_MAX_ZERO;
                mid_state.run_min = RUN_MIN_SHORT;
            end else begin
                mid_state.run_max = RUN_MAX_OTHER;
                mid_state.run_min = RUN_MIN_OTHER;
            end
            n1 = 2'd0;
        end
    end

    always_comb begin
        if (i_item.table_end) begin
            n2               = adv2_count;
            o_have_pending   = 1'b0;
            o_pending_length = 4'd0;
            o_state          = RUN_STATE_RESET;
        end else begin
            n2               = 2'd0;
            o_have_pending   = 1'b1;
            o_pending_length = len;
            o_state          = mid_state;
        end
    end

    always_comb begin
        kk       = 3'd0;
        j        = 3'd0;
        o_list   = '0;
        o_count  = {1'b0, n1} + {1'b0, n2};
        last_idx = o_count - 3'd1;
        for (int k = 0; k < 6; k++) begin
            kk = 3'(k);
            j  = kk - {1'b0, n1};
            if (kk < {1'b0, n1}) begin
                o_list[k] = adv1_res[kk[1:0]];
            end else if (j < {1'b0, n2}) begin
                o_list[k] = adv2_res[j[1:0]];
            end
        end
        if (o_count != 3'd0) begin
            o_list[last_idx].last_of_run = 1'b1;
            o_list[last_idx].table_done  = i_item.table_end;
        end
    end

    // flush state is dropped, the table restarts from reset
    logic unused_flush_state;
    assign unused_flush_state = ^adv2_state;

endmodule

// ===== rtl/clrle_out_fifo.sv =====
`timescale 1ns / 1ps

module clrle_out_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  clrle_pkg::t_out_item    i_push_item,
    output logic                    o_full,
    output logic                    o_valid,
    output clrle_pkg::t_out_item    o_item,
    input  logic                    i_stall
);
    import clrle_pkg::*;

    t_out_item [1:0] r_mem;
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            n_wr_ptr;
    logic            n_rd_ptr;
    logic [1:0]      n_count;
    logic            pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ===== rtl/code_length_run_length_encoder.sv =====
// the first result of a request is registered in the burst register, then in the output fifo, before it is valid
// throughput: one request a cycle while each causes at most one result and the output fifo is not full
// a request causing several results stalls intake until its last result moves into the output fifo, one a cycle
// reset: synchronous active low, run state returns to its start values, queued results dropped
`timescale 1ns / 1ps

module code_length_run_length_encoder (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  clrle_pkg::t_in_item     i_in_item,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output clrle_pkg::t_out_item    o_out_item,
    input  logic                    i_out_stall
);
    import clrle_pkg::*;

    logic             r_have_pending;
    logic [3:0]       r_pending_length;
    t_run_state       r_state;
    t_out_item [5:0]  r_burst;
    logic [2:0]       r_burst_cnt;

    t_out_item [5:0]  n_burst;
    logic [2:0]       n_burst_cnt;

    logic             step_have_pending;
    logic [3:0]       step_pending_length;
    t_run_state       step_state;
    t_out_item [5:0]  step_list;
    logic [2:0]       step_count;

    logic             fifo_full;
    logic             in_ready;
    logic             accept;
    logic             move;

    clrle_step u_step (
        .i_have_pending   (r_have_pending),
        .i_pending_length (r_pending_length),
        .i_state          (r_state),
        .i_item           (i_in_item),
        .o_have_pending   (step_have_pending),
        .o_pending_length (step_pending_length),
        .o_state          (step_state),
        .o_list           (step_list),
        .o_count          (step_count)
    );

    clrle_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (move),
        .i_push_item (r_burst[0]),
        .o_full      (fifo_full),
        .o_valid     (o_out_valid),
        .o_item      (o_out_item),
        .i_stall     (i_out_stall)
    );

    // a new request fits when the burst is empty or empties this cycle
    assign move       = (r_burst_cnt != 3'd0) && !fifo_full;
    assign in_ready   = (r_burst_cnt == 3'd0) || ((r_burst_cnt == 3'd1) && !fifo_full);
    assign o_in_stall = !in_ready;
    assign accept     = i_in_valid && in_ready;

    always_comb begin
        n_burst     = r_burst;
        n_burst_cnt = r_burst_cnt;
        if (accept) begin
            n_burst     = step_list;
            n_burst_cnt = step_count;
        end else if (move) begin
            n_burst     = {t_out_item'('0), r_burst[5:1]};
            n_burst_cnt = r_burst_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_pending   <= 1'b0;
            r_pending_length <= 4'd0;
            r_state          <= RUN_STATE_RESET;
            r_burst_cnt      <= 3'd0;
        end else begin
            r_burst_cnt <= n_burst_cnt;
            if (accept) begin
                r_have_pending   <= step_have_pending;
                r_pending_length <= step_pending_length;
                r_state          <= step_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_burst <= n_burst;
    end

endmodule

// ===== rtl/clrle_checker.sv =====
`timescale 1ns / 1ps
`include "code_length_run_length_encoder_assert.svh"

module clrle_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  clrle_pkg::t_in_item     i_in_item,
    input  logic                    i_in_stall,
    input  logic                    i_out_valid,
    input  clrle_pkg::t_out_item    i_out_item,
    input  logic                    i_out_stall
);
    import clrle_pkg::*;

    logic unused_in;
    logic stalled;
    logic done_bad;
    logic form_literal;
    logic form_repeat;
    logic form_short;
    logic form_long;
    logic form_ok;

    assign unused_in    = i_in_valid ^ (^i_in_item) ^ i_in_stall;
    assign stalled      = i_out_valid && i_out_stall;
    assign done_bad     = i_out_item.table_done && !i_out_item.last_of_run;
    assign form_literal = (i_out_item.symbol < SYM_REPEAT) && (i_out_item.extra_width == 3'd0)
                          && (i_out_item.extra_value == 7'd0);
    assign form_repeat  = (i_out_item.symbol == SYM_REPEAT)
                          && (i_out_item.extra_width == EW_REPEAT)
                          && (i_out_item.extra_value <= 7'd3);
    assign form_short   = (i_out_item.symbol == SYM_ZEROS_SHORT)
                          && (i_out_item.extra_width == EW_ZEROS_SHORT)
                          && (i_out_item.extra_value <= 7'd7);
    assign form_long    = (i_out_item.symbol == SYM_ZEROS_LONG)
                          && (i_out_item.extra_width == EW_ZEROS_LONG);
    assign form_ok      = form_literal || form_repeat || form_short || form_long;

    `CLRLE_ASSERT(a_out_valid_held, i_clk, i_rst_n, stalled |=> i_out_valid, "result dropped")
    `CLRLE_ASSERT(a_item_held, i_clk, i_rst_n, stalled |=> $stable(i_out_item), "item changed")
    `CLRLE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "valid after reset")
    `CLRLE_ASSERT(a_done_is_last, i_clk, i_rst_n, i_out_valid |-> !done_bad, "done not last")
    `CLRLE_ASSERT(a_symbol_form, i_clk, i_rst_n, i_out_valid |-> form_ok, "malformed symbol")

endmodule

bind code_length_run_length_encoder clrle_checker u_clrle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

// ===== bench/clrle_checker.sv =====
`timescale 1ns / 1ps

module clrle_scoreboard (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  clrle_pkg::t_in_item  i_in_item,
    input  logic                 i_in_stall,
    input  logic                 i_out_valid,
    input  clrle_pkg::t_out_item i_out_item,
    input  logic                 i_out_stall,
    output int                   o_fail_count,
    output int                   o_waiting,
    output int                   o_checked
);
    import clrle_pkg::*;

    logic       have_held;
    logic [3:0] held_length;
    logic [7:0] run_count;
    logic [4:0] last_emitted;
    logic [7:0] run_max;
    logic [2:0] run_min;
    t_out_item  burst[6];
    int         burst_len = 0;
    t_out_item  expected_symbols[$];
    int         fails = 0;
    int         checked = 0;

    task automatic clear_run_state();
        have_held    = 1'b0;
        held_length  = 4'd0;
        run_count    = 8'd0;
        last_emitted = NO_LENGTH;
        run_max      = RUN_MAX_OTHER;
        run_min      = RUN_MIN_OTHER;
    endtask

    task automatic emit_symbol(input logic [4:0] sym, input logic [6:0] extra,
                               input logic [2:0] width);
        t_out_item r;
        r.symbol      = sym;
        r.extra_value = extra;
        r.extra_width = width;
        r.last_of_run = 1'b0;
        r.table_done  = 1'b0;
        if (burst_len < 6) begin
            burst[burst_len] = r;
            burst_len++;
        end
    endtask

    // close or extend the held run, looking at the length that follows it
    task automatic close_run(input logic [3:0] cur, input logic [3:0] nxt, input logic flush);
        logic [7:0] cnt;
        logic [7:0] over;
        cnt = run_count + 8'd1;
        if (!flush && cnt < run_max && cur == nxt) begin
            run_count = cnt;
            return;
        end
        if (cnt < {5'd0, run_min}) begin
            repeat (cnt) emit_symbol({1'b0, cur}, 7'd0, 3'd0);
        end else if (cur != 4'd0) begin
            if ({1'b0, cur} != last_emitted) begin
                emit_symbol({1'b0, cur}, 7'd0, 3'd0);
                cnt = cnt - 8'd1;
            end
            over = cnt - REPEAT_BASE;
            emit_symbol(SYM_REPEAT, (cnt >= REPEAT_BASE) ? {5'd0, over[1:0]} : 7'd0,
                        EW_REPEAT);
        end else if (cnt <= SHORT_ZERO_MAX) begin
            over = cnt - REPEAT_BASE;
            emit_symbol(SYM_ZEROS_SHORT, (cnt >= REPEAT_BASE) ? {4'd0, over[2:0]} : 7'd0,
                        EW_ZEROS_SHORT);
        end else begin
            over = cnt - LONG_ZERO_BASE;
            emit_symbol(SYM_ZEROS_LONG, over[6:0], EW_ZEROS_LONG);
        end
        run_count    = 8'd0;
        last_emitted = {1'b0, cur};
        if (flush) begin
            run_max = RUN_MAX_OTHER;
            run_min = RUN_MIN_OTHER;
        end else if (nxt == 4'd0) begin
            run_max = RUN_MAX_ZERO;
            run_min = RUN_MIN_SHORT;
        end else if (cur == nxt) begin
            run_max = RUN_MAX_REPEAT;
            run_min = RUN_MIN_SHORT;
        end else begin
            run_max = RUN_MAX_OTHER;
            run_min = RUN_MIN_OTHER;
        end
    endtask

    task automatic predict_request(input t_in_item req);
        t_out_item tail;
        burst_len = 0;
        if (!have_held) begin
            last_emitted = NO_LENGTH;
            run_count    = 8'd0;
            if (req.code_length == 4'd0) begin
                run_max = RUN_MAX_ZERO;
                run_min = RUN_MIN_SHORT;
            end else begin
                run_max = RUN_MAX_OTHER;
                run_min = RUN_MIN_OTHER;
            end
            have_held = 1'b1;
        end else begin
            close_run(held_length, req.code_length, 1'b0);
        end
        held_length = req.code_length;
        if (req.table_end) begin
            close_run(held_length, 4'd0, 1'b1);
            clear_run_state();
        end
        if (burst_len > 0) begin
            tail             = burst[burst_len - 1];
            tail.last_of_run = 1'b1;
            tail.table_done  = req.table_end;
            burst[burst_len - 1] = tail;
        end
        for (int i = 0; i < burst_len; i++) expected_symbols.push_back(burst[i]);
    endtask

    task automatic check_symbol(input t_out_item got);
        t_out_item want;
        if (expected_symbols.size() == 0) begin
            if (fails < 10)
                $display("unexpected symbol %0d extra %0d/%0d with nothing pending",
                         got.symbol, got.extra_value, got.extra_width);
            fails++;
        end else begin
            want = expected_symbols.pop_front();
            checked++;
            if (got !== want) begin
                if (fails < 10)
                    $display("mismatch: expected %0d/%0d/%0d/%b/%b got %0d/%0d/%0d/%b/%b",
                             want.symbol, want.extra_value, want.extra_width,
                             want.last_of_run, want.table_done,
                             got.symbol, got.extra_value, got.extra_width,
                             got.last_of_run, got.table_done);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_run_state();
            expected_symbols.delete();
        end else begin
            if (i_in_valid && !i_in_stall) predict_request(i_in_item);
            if (i_out_valid && !i_out_stall) check_symbol(i_out_item);
        end
        o_fail_count <= fails;
        o_waiting    <= expected_symbols.size();
        o_checked    <= checked;
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import clrle_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_item = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_item;
    logic       out_stall = 1'b0;
    logic       calm = 1'b0;
    int         fail_count;
    int         waiting;
    int         checked;
    int         requests_sent = 0;
    int         tables_sent = 0;
    logic [3:0] table_lengths[$];

    always #5 clk = ~clk;

    code_length_run_length_encoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    clrle_scoreboard symbol_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_item    (in_item),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_item   (out_item),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_checked    (checked)
    );

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < 6);
        end
    end

    task automatic send_request(input logic [3:0] len, input logic last);
        if (!calm && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{code_length: len, table_end: last};
        do @(posedge clk); while (in_stall);
        requests_sent++;
        calm <= (requests_sent >= 200 && requests_sent < 300);
    endtask

    task automatic send_table();
        tables_sent++;
        foreach (table_lengths[i])
            send_request(table_lengths[i], i == table_lengths.size() - 1);
    endtask

    // mostly tables built from runs, some of pure noise
    task automatic build_random_table();
        int         run_len;
        logic [3:0] value;
        table_lengths.delete();
        value = 4'd0;
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(20, 1)) begin
                value = 4'($urandom_range(15));
                table_lengths.push_back(value);
            end
        end else begin
            repeat ($urandom_range(8, 1)) begin
                if ($urandom_range(39) == 0) begin
                    value   = 4'd0;
                    run_len = $urandom_range(150, 120);
                end else begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: value = 4'd0;
                        4, 5: ;
                        default: value = 4'($urandom_range(15));
                    endcase
                    run_len = $urandom_range(12, 1);
                end
                repeat (run_len) table_lengths.push_back(value);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        table_lengths = '{4'd5};
        send_table();
        table_lengths = '{4'd0};
        send_table();
        table_lengths = '{4'd15};
        send_table();
        table_lengths = '{4'd0, 4'd0, 4'd0};
        send_table();
        table_lengths = '{4'd7, 4'd7, 4'd7, 4'd7};
        send_table();
        table_lengths = '{4'd3, 4'd4};
        send_table();
        table_lengths = '{4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9};
        send_table();
        table_lengths = '{4'd0, 4'd0, 4'd15};
        send_table();

        while (requests_sent < 420) begin
            build_random_table();
            send_table();
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d length tables in %0d requests, compared %0d symbols",
                 tables_sent, requests_sent, checked);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timed out with %0d symbols outstanding", waiting);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/clrle_pkg.sv
rtl/clrle_advance.sv
rtl/clrle_step.sv
rtl/clrle_out_fifo.sv
rtl/code_length_run_length_encoder.sv
rtl/clrle_checker.sv
bench/clrle_checker.sv
bench/tb.sv
